// ----- rtl/tle_pkg.sv -----
// Shared constants and types of the tour length evaluator.
// Used by every module under rtl; depends on nothing else.
package tle_pkg;

    localparam int MAX_CITIES    = 32;
    localparam int FRACTION_BITS = 8;

    localparam int CITY_W   = 5;
    localparam int COORD_W  = 10;
    localparam int LEN_W    = 24;
    localparam int CITY_AW  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int ENTRY_W  = 2 * COORD_W;

    // Squared distance and the square root that follows from it.
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RAD_W      = SUM_W + 2 * FRACTION_BITS;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int RAD2_W     = 2 * ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int REM_W      = ROOT_W + 2;
    localparam int ACC_W      = ((ROOT_W > LEN_W) ? ROOT_W : LEN_W) + 1;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TOUR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/tle_city_ram.sv -----
// City coordinate table: one write port, two registered read ports.
// Depends on tle_pkg.
module tle_city_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [tle_pkg::CITY_W-1:0]   wr_city,
    input  logic [tle_pkg::ENTRY_W-1:0]  wr_data,
    input  logic [tle_pkg::CITY_W-1:0]   rd_city_a,
    input  logic [tle_pkg::CITY_W-1:0]   rd_city_b,
    output logic [tle_pkg::ENTRY_W-1:0]  rd_data_a,
    output logic [tle_pkg::ENTRY_W-1:0]  rd_data_b
);

    logic [tle_pkg::ENTRY_W-1:0] mem [tle_pkg::MAX_CITIES];
    logic [tle_pkg::ENTRY_W-1:0] rd_data_a_reg;
    logic [tle_pkg::ENTRY_W-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && (int'(wr_city) < tle_pkg::MAX_CITIES)) begin
            mem[tle_pkg::CITY_AW'(wr_city)] <= wr_data;
        end
    end

    // Slots beyond the table read as the origin.
    always_ff @(posedge aclk) begin
        if (int'(rd_city_a) < tle_pkg::MAX_CITIES) begin
            rd_data_a_reg <= mem[tle_pkg::CITY_AW'(rd_city_a)];
        end else begin
            rd_data_a_reg <= '0;
        end
        if (int'(rd_city_b) < tle_pkg::MAX_CITIES) begin
            rd_data_b_reg <= mem[tle_pkg::CITY_AW'(rd_city_b)];
        end else begin
            rd_data_b_reg <= '0;
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- rtl/tle_isqrt.sv -----
// Digit-serial floor square root, two radicand bits per cycle.
// Depends on tle_pkg.
module tle_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tle_pkg::SUM_W-1:0]   radicand,
    output logic [tle_pkg::ROOT_W-1:0]  root,
    output logic                        done
);

    logic [tle_pkg::RAD2_W-1:0]     rad_reg, rad_next;
    logic [tle_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [tle_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [tle_pkg::ROOT_CNT_W-1:0] count_reg, count_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [tle_pkg::REM_W-1:0] rem_shift;
    logic [tle_pkg::REM_W-1:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        count_reg <= count_next;
    end

    always_comb begin
        // The remainder never exceeds twice the partial root, so its top two
        // bits are zero before each shift.
        rem_shift  = {rem_reg[tle_pkg::REM_W-3:0], rad_reg[tle_pkg::RAD2_W-1 -: 2]};
        trial      = {root_reg, 2'b01};
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rad_next   = tle_pkg::RAD2_W'(radicand) << (2 * tle_pkg::FRACTION_BITS);
            rem_next   = '0;
            root_next  = '0;
            count_next = tle_pkg::ROOT_CNT_W'(tle_pkg::ROOT_W - 1);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[tle_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[tle_pkg::ROOT_W-2:0], 1'b0};
            end
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ----- rtl/tour_length_evaluator_unit.sv -----
// Tour length evaluator: a load request only writes the table and the block is ready again at once.
// A tour request that adds an edge holds off the input while it runs a table read,
// a difference, a square, the digit-serial square root and an accumulate.
// The request marked last runs the closing edge too (only that edge when it also opens
// the tour) and then places the total in the output register once that register is free.
// Reset (aresetn, synchronous, active low) ends any tour and drops the output.
//
// Depends on tle_pkg, tle_city_ram and tle_isqrt; the coordinate table is not cleared.
module tour_length_evaluator_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [tle_pkg::CITY_W-1:0]  s_city_index,
    input  logic [tle_pkg::COORD_W-1:0] s_coord_x,
    input  logic [tle_pkg::COORD_W-1:0] s_coord_y,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tle_pkg::LEN_W-1:0]   m_tour_length
);

    tle_pkg::state_t state_reg, state_next;

    // Tour state. The tour_open flag, the pending flags and the running sum are control
    // and take the reset; the city indices and the output total are payload.
    logic                         tour_open_reg, tour_open_next;
    logic                         closing_reg, closing_next;
    logic                         final_reg, final_next;
    logic [tle_pkg::CITY_W-1:0]   first_city_reg, first_city_next;
    logic [tle_pkg::CITY_W-1:0]   prev_city_reg, prev_city_next;
    logic [tle_pkg::CITY_W-1:0]   from_reg, from_next;
    logic [tle_pkg::CITY_W-1:0]   to_reg, to_next;
    logic [tle_pkg::LEN_W-1:0]    running_reg, running_next;
    logic [tle_pkg::COORD_W-1:0]  dx_reg, dx_next;
    logic [tle_pkg::COORD_W-1:0]  dy_reg, dy_next;
    logic                         m_valid_reg, m_valid_next;
    logic [tle_pkg::LEN_W-1:0]    m_len_reg, m_len_next;

    logic                         accept;
    logic                         load_wr;
    logic [tle_pkg::ENTRY_W-1:0]  rd_from;
    logic [tle_pkg::ENTRY_W-1:0]  rd_to;
    logic [tle_pkg::COORD_W-1:0]  ax, ay, bx, by;
    logic [tle_pkg::SQ_W-1:0]     sq_x, sq_y;
    logic [tle_pkg::SUM_W-1:0]    sq_sum;
    logic                         root_start;
    logic [tle_pkg::ROOT_W-1:0]   edge_root;
    logic                         root_done;
    logic [tle_pkg::ACC_W-1:0]    acc_sum;

    assign accept  = s_valid && s_ready;
    assign load_wr = accept && (s_kind == tle_pkg::KIND_LOAD);

    // The table is read at the two ends of the current edge every cycle; the edge
    // ends pass through the from/to registers and the table's read registers before use.
    tle_city_ram u_city_ram (
        .aclk      (aclk),
        .wr_en     (load_wr),
        .wr_city   (s_city_index),
        .wr_data   ({s_coord_x, s_coord_y}),
        .rd_city_a (from_reg),
        .rd_city_b (to_reg),
        .rd_data_a (rd_from),
        .rd_data_b (rd_to)
    );

    tle_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (sq_sum),
        .root     (edge_root),
        .done     (root_done)
    );

    assign ax = rd_from[tle_pkg::ENTRY_W-1 -: tle_pkg::COORD_W];
    assign ay = rd_from[tle_pkg::COORD_W-1:0];
    assign bx = rd_to[tle_pkg::ENTRY_W-1 -: tle_pkg::COORD_W];
    assign by = rd_to[tle_pkg::COORD_W-1:0];

    // Squared edge length from the registered coordinate differences.
    assign sq_x   = tle_pkg::SQ_W'(dx_reg) * tle_pkg::SQ_W'(dx_reg);
    assign sq_y   = tle_pkg::SQ_W'(dy_reg) * tle_pkg::SQ_W'(dy_reg);
    assign sq_sum = tle_pkg::SUM_W'(sq_x) + tle_pkg::SUM_W'(sq_y);

    // Running sum plus the new edge, before saturation.
    assign acc_sum = tle_pkg::ACC_W'(running_reg) + tle_pkg::ACC_W'(edge_root);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tle_pkg::ST_IDLE;
            tour_open_reg <= 1'b0;
            closing_reg   <= 1'b0;
            final_reg     <= 1'b0;
            running_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tour_open_reg <= tour_open_next;
            closing_reg   <= closing_next;
            final_reg     <= final_next;
            running_reg   <= running_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_city_reg <= first_city_next;
        prev_city_reg  <= prev_city_next;
        from_reg       <= from_next;
        to_reg         <= to_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        m_len_reg      <= m_len_next;
    end

    always_comb begin
        state_next      = state_reg;
        tour_open_next  = tour_open_reg;
        closing_next    = closing_reg;
        final_next      = final_reg;
        first_city_next = first_city_reg;
        prev_city_next  = prev_city_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        running_next    = running_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        m_len_next      = m_len_reg;
        m_valid_next    = m_valid_reg;
        s_ready         = 1'b0;
        root_start      = 1'b0;

        // The output register drains independently of the work in progress.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tle_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept && (s_kind == tle_pkg::KIND_TOUR)) begin
                    if (!tour_open_reg) begin
                        // The first city of a tour adds no edge. If it is also
                        // the last, the closing edge runs from the city to itself.
                        first_city_next = s_city_index;
                        prev_city_next  = s_city_index;
                        running_next    = '0;
                        tour_open_next  = 1'b1;
                        if (s_last) begin
                            from_next    = s_city_index;
                            to_next      = s_city_index;
                            closing_next = 1'b0;
                            final_next   = 1'b1;
                            state_next   = tle_pkg::ST_READ;
                        end
                    end else begin
                        from_next      = prev_city_reg;
                        to_next        = s_city_index;
                        prev_city_next = s_city_index;
                        closing_next   = s_last;
                        final_next     = 1'b0;
                        state_next     = tle_pkg::ST_READ;
                    end
                end
            end
            tle_pkg::ST_READ: begin
                state_next = tle_pkg::ST_DIFF;
            end
            tle_pkg::ST_DIFF: begin
                dx_next    = (ax > bx) ? ax - bx : bx - ax;
                dy_next    = (ay > by) ? ay - by : by - ay;
                state_next = tle_pkg::ST_SQUARE;
            end
            tle_pkg::ST_SQUARE: begin
                root_start = 1'b1;
                state_next = tle_pkg::ST_ROOT;
            end
            tle_pkg::ST_ROOT: begin
                if (root_done) begin
                    if (acc_sum > tle_pkg::ACC_W'(tle_pkg::LEN_MAX)) begin
                        running_next = tle_pkg::LEN_MAX;
                    end else begin
                        running_next = tle_pkg::LEN_W'(acc_sum);
                    end
                    if (closing_reg) begin
                        // The last city of the tour still owes the edge back
                        // to the first one.
                        from_next    = prev_city_reg;
                        to_next      = first_city_reg;
                        closing_next = 1'b0;
                        final_next   = 1'b1;
                        state_next   = tle_pkg::ST_READ;
                    end else if (final_reg) begin
                        state_next = tle_pkg::ST_EMIT;
                    end else begin
                        state_next = tle_pkg::ST_IDLE;
                    end
                end
            end
            tle_pkg::ST_EMIT: begin
                // Wait for the output register to be free, then hand over the
                // total and close the tour.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_len_next     = running_reg;
                    running_next   = '0;
                    tour_open_next = 1'b0;
                    final_next     = 1'b0;
                    state_next     = tle_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_tour_length = m_len_reg;

endmodule

// ----- rtl/tle_checker.sv -----
// Port-level checks of the tour length evaluator, bound to its top level.
// Depends on tle_pkg and on the ports of tour_length_evaluator_unit.
module tle_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_kind,
    input logic [tle_pkg::CITY_W-1:0]  s_city_index,
    input logic [tle_pkg::COORD_W-1:0] s_coord_x,
    input logic [tle_pkg::COORD_W-1:0] s_coord_y,
    input logic                        s_last,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tle_pkg::LEN_W-1:0]   m_tour_length
);

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result still offered after reset");

    // A result that was not taken stays offered and unchanged.
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tour_length))
        else $error("result dropped or changed before it was taken");

    // A load request only writes the table, so the block takes the next one at once.
    a_load_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == tle_pkg::KIND_LOAD) |=> s_ready)
        else $error("block stalled after a load request");

    // A tour request marked last always starts edge work and holds off the input.
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == tle_pkg::KIND_TOUR) && s_last |=> !s_ready)
        else $error("block ready right after a closing tour request");

endmodule

bind tour_length_evaluator_unit tle_checker u_tle_checker (.*);

// ----- tb/sv/tb_tour_length_evaluator_unit.sv -----
// Self-checking testbench for tour_length_evaluator_unit: it loads city coordinates, streams
// tours and checks every emitted closed-tour length against a cycle-free predictor.
// Depends on tle_pkg and the RTL of the evaluator; it reads no files.
module tb_tour_length_evaluator_unit;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int ITEM_TARGET    = 1350;
    localparam int HOLDOFF_CYCLES = 400;
    // The drain waits longer than a closing request takes.
    localparam int DRAIN_CYCLES   = 80;
    // Many times the slowest correct run with every stall included.
    localparam int RUN_LIMIT      = 4_000_000;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic                         s_kind        = tle_pkg::KIND_LOAD;
    logic [tle_pkg::CITY_W-1:0]   s_city_index  = '0;
    logic [tle_pkg::COORD_W-1:0]  s_coord_x     = '0;
    logic [tle_pkg::COORD_W-1:0]  s_coord_y     = '0;
    logic                         s_last        = 1'b0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic [tle_pkg::LEN_W-1:0]    m_tour_length;

    // Run control shared by the stimulus, the receiver and the hold-off process.
    logic quiet_phase   = 1'b0;
    logic holdoff_armed = 1'b0;
    logic receiver_held = 1'b0;

    int requests_sent    = 0;
    int lengths_checked  = 0;
    int saturated_tours  = 0;
    int mismatch_count   = 0;

    // Predictor state: our own copy of the coordinate table and the tour in progress.
    logic [tle_pkg::COORD_W-1:0]    city_x [tle_pkg::MAX_CITIES];
    logic [tle_pkg::COORD_W-1:0]    city_y [tle_pkg::MAX_CITIES];
    logic [tle_pkg::MAX_CITIES-1:0] city_loaded = '0;
    logic [tle_pkg::CITY_W-1:0]     tour_first  = '0;
    logic [tle_pkg::CITY_W-1:0]     tour_prev   = '0;
    logic [tle_pkg::LEN_W-1:0]      tour_sum    = '0;
    logic                           tour_active = 1'b0;

    // Tour lengths that the block still owes us, oldest first.
    logic [tle_pkg::LEN_W-1:0] pending_lengths [$];

    tour_length_evaluator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_city_index  (s_city_index),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tour_length (m_tour_length)
    );

    always #CLK_HALF aclk = ~aclk;

    // Floor square root found one result bit at a time, from the top bit down.
    function automatic longint unsigned root_floor(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Length of one edge in fixed point, using the predictor's table.
    function automatic longint unsigned edge_distance(
        input logic [tle_pkg::CITY_W-1:0] from_city,
        input logic [tle_pkg::CITY_W-1:0] to_city);
        longint unsigned dx;
        longint unsigned dy;
        dx = (city_x[from_city] > city_x[to_city]) ? city_x[from_city] - city_x[to_city]
                                                   : city_x[to_city] - city_x[from_city];
        dy = (city_y[from_city] > city_y[to_city]) ? city_y[from_city] - city_y[to_city]
                                                   : city_y[to_city] - city_y[from_city];
        return root_floor((dx * dx + dy * dy) << (2 * tle_pkg::FRACTION_BITS));
    endfunction

    function automatic logic [tle_pkg::LEN_W-1:0] saturating_add(
        input logic [tle_pkg::LEN_W-1:0] sum, input longint unsigned edge_len);
        longint unsigned total;
        total = longint'(sum) + edge_len;
        return (total > longint'(tle_pkg::LEN_MAX)) ? tle_pkg::LEN_MAX
                                                    : total[tle_pkg::LEN_W-1:0];
    endfunction

    // Advance the predictor by one accepted request; a closing tour request queues its length.
    task automatic predict_tour_length(input logic kind, input logic [tle_pkg::CITY_W-1:0] idx,
                                       input logic [tle_pkg::COORD_W-1:0] x,
                                       input logic [tle_pkg::COORD_W-1:0] y, input logic last);
        if (kind == tle_pkg::KIND_LOAD) begin
            // Every 5-bit index addresses a real slot, so no load is dropped.
            city_x[idx] = x;
            city_y[idx] = y;
            city_loaded[idx] = 1'b1;
        end else begin
            if (!tour_active) begin
                tour_first  = idx;
                tour_prev   = idx;
                tour_sum    = '0;
                tour_active = 1'b1;
            end else begin
                tour_sum  = saturating_add(tour_sum, edge_distance(tour_prev, idx));
                tour_prev = idx;
            end
            if (last) begin
                tour_sum = saturating_add(tour_sum, edge_distance(tour_prev, tour_first));
                pending_lengths.push_back(tour_sum);
                if (tour_sum == tle_pkg::LEN_MAX) begin
                    saturated_tours++;
                end
                tour_sum    = '0;
                tour_active = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [tle_pkg::LEN_W-1:0] want,
                                   input logic [tle_pkg::LEN_W-1:0] got);
        $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        mismatch_count++;
    endtask

    // Offer one request and hold it until the block accepts it. Random idle cycles come first,
    // so valid only drops between requests.
    task automatic send_request(input logic kind, input logic [tle_pkg::CITY_W-1:0] idx,
                                input logic [tle_pkg::COORD_W-1:0] x,
                                input logic [tle_pkg::COORD_W-1:0] y,
                                input logic last);
        if (!quiet_phase) begin
            while ($urandom_range(99) < 6) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_city_index <= idx;
        s_coord_x    <= x;
        s_coord_y    <= y;
        s_last       <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_tour_length(kind, idx, x, y, last);
        requests_sent++;
    endtask

    // Coordinates lean toward the ends of the range so the extremes come up often.
    function automatic logic [tle_pkg::COORD_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 20) begin
            return {tle_pkg::COORD_W{1'b1}};
        end
        return tle_pkg::COORD_W'($urandom_range(2**tle_pkg::COORD_W - 1));
    endfunction

    // Tours only visit slots that have been loaded, so no undefined entry is ever read.
    function automatic logic [tle_pkg::CITY_W-1:0] random_loaded_city();
        logic [tle_pkg::CITY_W-1:0] idx;
        do begin
            idx = tle_pkg::CITY_W'($urandom_range(tle_pkg::MAX_CITIES - 1));
        end while (!city_loaded[idx]);
        return idx;
    endfunction

    task automatic send_random_load();
        send_request(tle_pkg::KIND_LOAD,
                     tle_pkg::CITY_W'($urandom_range(tle_pkg::MAX_CITIES - 1)),
                     random_coord(), random_coord(), 1'($urandom_range(1)));
    endtask

    // Tour requests carry random coordinates, which the block must ignore.
    task automatic send_tour_city(input logic [tle_pkg::CITY_W-1:0] idx, input logic last);
        send_request(tle_pkg::KIND_TOUR, idx,
                     tle_pkg::COORD_W'($urandom_range(2**tle_pkg::COORD_W - 1)),
                     tle_pkg::COORD_W'($urandom_range(2**tle_pkg::COORD_W - 1)), last);
    endtask

    // Corner cities, a one-city tour, a zero-length edge, a load in the middle of a tour,
    // and a load that carries the last flag.
    task automatic test_directed_tours();
        send_request(tle_pkg::KIND_LOAD, 5'd0,  10'd0,    10'd0,    1'b0);
        send_request(tle_pkg::KIND_LOAD, 5'd31, 10'd1023, 10'd1023, 1'b0);
        send_request(tle_pkg::KIND_LOAD, 5'd1,  10'd1023, 10'd0,    1'b1);
        send_request(tle_pkg::KIND_LOAD, 5'd2,  10'd0,    10'd1023, 1'b1);
        send_request(tle_pkg::KIND_LOAD, 5'd21, 10'd682,  10'd341,  1'b0);
        // A tour that opens and closes on one request has length zero.
        send_tour_city(5'd31, 1'b1);
        // The longest possible edge, out and back.
        send_tour_city(5'd0,  1'b0);
        send_tour_city(5'd31, 1'b1);
        // Square around the corners, with one repeated city.
        send_tour_city(5'd0,  1'b0);
        send_tour_city(5'd1,  1'b0);
        send_tour_city(5'd1,  1'b0);
        send_tour_city(5'd31, 1'b0);
        send_tour_city(5'd2,  1'b1);
        // Move city 1 while a tour is open; the next edge must use the new place.
        send_tour_city(5'd21, 1'b0);
        send_tour_city(5'd2,  1'b0);
        send_request(tle_pkg::KIND_LOAD, 5'd1, 10'd3, 10'd4, 1'b1);
        send_tour_city(5'd1,  1'b0);
        send_tour_city(5'd0,  1'b1);
        // The same city twice gives a zero total.
        send_tour_city(5'd21, 1'b0);
        send_tour_city(5'd21, 1'b1);
    endtask

    // Stall the receiver for a long stretch while short tours keep arriving, so the output
    // register fills and the block has to hold off the input side.
    task automatic test_output_backpressure();
        holdoff_armed <= 1'b1;
        repeat (5) begin
            send_tour_city(random_loaded_city(), 1'b0);
            send_tour_city(random_loaded_city(), 1'b1);
        end
    endtask

    // A long tour between opposite corners drives the sum into saturation.
    task automatic test_length_saturation();
        send_request(tle_pkg::KIND_LOAD, 5'd0,  10'd0,    10'd0,    1'b0);
        send_request(tle_pkg::KIND_LOAD, 5'd31, 10'd1023, 10'd1023, 1'b0);
        for (int i = 0; i < 60; i++) begin
            send_tour_city((i % 2 == 0) ? 5'd0 : 5'd31, 1'(i == 59));
        end
    endtask

    // Random tours of mixed length, with loads between tours and now and then inside one.
    // A stretch in the middle runs with no idling on either side.
    task automatic test_random_tours();
        int tour_len;
        int pick;
        while (requests_sent < ITEM_TARGET - 70) begin
            quiet_phase <= (requests_sent >= 500 && requests_sent < 800);
            repeat ($urandom_range(2)) begin
                send_random_load();
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                tour_len = 1;
            end else if (pick < 85) begin
                tour_len = $urandom_range(8, 2);
            end else begin
                tour_len = $urandom_range(30, 9);
            end
            for (int i = 0; i < tour_len; i++) begin
                if ($urandom_range(99) < 8) begin
                    send_random_load();
                end
                send_tour_city(random_loaded_city(), 1'(i == tour_len - 1));
            end
        end
        quiet_phase <= 1'b0;
    endtask

    // Receiver: checks each accepted length against the oldest prediction, then picks the
    // ready level for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_lengths.size() == 0) begin
                report_mismatch("unexpected tour length", '0, m_tour_length);
            end else begin
                if (m_tour_length !== pending_lengths[0]) begin
                    report_mismatch("tour length", pending_lengths[0], m_tour_length);
                end
                void'(pending_lengths.pop_front());
                lengths_checked++;
            end
        end
        if (receiver_held) begin
            m_ready <= 1'b0;
        end else if (quiet_phase) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 6);
        end
    end

    // Long receiver hold-off, counted here once a test asks for it.
    initial begin : receiver_holdoff
        wait (holdoff_armed);
        @(posedge aclk);
        receiver_held <= 1'b1;
        repeat (HOLDOFF_CYCLES) begin
            @(posedge aclk);
        end
        receiver_held <= 1'b0;
    end

    initial begin : run_limit
        #RUN_LIMIT;
        $display("timeout with %0d tour lengths outstanding", pending_lengths.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) begin
            @(posedge aclk);
        end
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_tours();
        test_output_backpressure();
        test_random_tours();
        test_length_saturation();
        s_valid <= 1'b0;

        while (pending_lengths.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) begin
            @(posedge aclk);
        end
        if (pending_lengths.size() != 0) begin
            report_mismatch("missing tour lengths", '0,
                            tle_pkg::LEN_W'(pending_lengths.size()));
        end

        $display("covered %0d requests and checked %0d closed tours (%0d saturated),",
                 requests_sent, lengths_checked, saturated_tours);
        $display("with random idling, a long output stall and %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tle_pkg.sv
rtl/tle_city_ram.sv
rtl/tle_isqrt.sv
rtl/tour_length_evaluator_unit.sv
rtl/tle_checker.sv
tb/sv/tb_tour_length_evaluator_unit.sv
